>>> src/gbi_pkg.sv
// Shared types and constants for the grid bilinear interpolation block.
// Used by every module in src but gbi_div; depends on nothing else.
`default_nettype none

package gbi_pkg;

  // Default sizes; the top level hands the real values down as parameters.
  localparam int DEF_MAX_OUTER = 64;
  localparam int DEF_MAX_INNER = 64;
  localparam int DEF_FRAC_BITS = 16;

  // Fixed field widths of the ports and registers, and the queue depth.
  localparam int CNT_W       = 7;
  localparam int IDX_W       = 12;
  localparam int DATA_W      = 32;
  localparam int CELL_W      = 6;
  localparam int PADDR_W     = 3;
  localparam int PDATA_W     = 32;
  localparam int QUEUE_DEPTH = 2;

  // Request codes carried by req_type.
  typedef enum logic [1:0] {
    REQ_LOAD_OUTER,
    REQ_LOAD_INNER,
    REQ_LOAD_TABLE,
    REQ_QUERY
  } gbi_req_e;

  // Configuration register indexes (paddr bit 2).
  typedef enum logic {
    REG_OUTER_POINTS,
    REG_INNER_POINTS
  } gbi_reg_e;

  // Blend passes of one query.
  typedef enum logic [1:0] {
    PASS_LEFT,
    PASS_RIGHT,
    PASS_FINAL
  } gbi_pass_e;

  // Back end sequencer states.
  typedef enum logic [4:0] {
    S_IDLE,
    S_FIRST,
    S_LAST,
    S_SETUP,
    S_PROBE,
    S_STEP,
    S_CLAMP,
    S_RLO,
    S_RHI,
    S_DIV,
    S_WAIT,
    S_T0,
    S_T1,
    S_T2,
    S_T3,
    S_T4,
    S_BD,
    S_BM0,
    S_BM1,
    S_BACC,
    S_BFIN
  } gbi_state_e;

  // One classified item in the queue between front and back.
  typedef struct packed {
    gbi_req_e                  kind;
    logic [IDX_W-1:0]          index;
    logic signed [DATA_W-1:0]  data;
    logic signed [DATA_W-1:0]  q_outer;
    logic signed [DATA_W-1:0]  q_inner;
  } gbi_item_t;

  // Effective point counts, already clamped to the legal range.
  typedef struct packed {
    logic [CNT_W-1:0] n_outer;
    logic [CNT_W-1:0] n_inner;
  } gbi_cfg_t;

endpackage

`default_nettype wire

>>> src/gbi_front.sv
// Front end: takes item transfers, drops loads that fall outside the stores,
// and holds the configuration registers. Depends on gbi_pkg.
`default_nettype none

module gbi_front #(
  parameter int MAX_OUTER_POINTS = gbi_pkg::DEF_MAX_OUTER,
  parameter int MAX_INNER_POINTS = gbi_pkg::DEF_MAX_INNER
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  input  wire logic [1:0]                     req_type_i,
  input  wire logic [gbi_pkg::IDX_W-1:0]      load_index_i,
  input  wire logic signed [31:0]             load_data_i,
  input  wire logic signed [31:0]             query_outer_i,
  input  wire logic signed [31:0]             query_inner_i,
  input  wire logic                           queue_full_i,
  output gbi_pkg::gbi_item_t                  item_o,
  output logic                                push_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [gbi_pkg::PADDR_W-1:0]    paddr,
  input  wire logic [gbi_pkg::PDATA_W-1:0]    pwdata,
  output logic [gbi_pkg::PDATA_W-1:0]         prdata,
  output logic                                pready,
  output gbi_pkg::gbi_cfg_t                   cfg_o
);
  import gbi_pkg::*;

  localparam int TABLE_DEPTH = MAX_OUTER_POINTS * MAX_INNER_POINTS;

  logic [CNT_W-1:0] outer_pts_q, outer_pts_d;
  logic [CNT_W-1:0] inner_pts_q, inner_pts_d;
  logic             keep;
  logic             wr_en;

  // Clamp a point count register to the range the search can use.
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] r, input int maxp);
    logic [CNT_W-1:0] v;
    if (r < CNT_W'(2)) begin
      v = CNT_W'(2);
    end else if (int'(r) > maxp) begin
      v = CNT_W'(maxp);
    end else begin
      v = r;
    end
    return v;
  endfunction

  // Classify the item: loads beyond a store's depth are dropped.
  always_comb begin
    item_o.kind    = gbi_req_e'(req_type_i);
    item_o.index   = load_index_i;
    item_o.data    = load_data_i;
    item_o.q_outer = query_outer_i;
    item_o.q_inner = query_inner_i;
    unique case (gbi_req_e'(req_type_i))
      REQ_LOAD_OUTER: keep = int'(load_index_i) < MAX_OUTER_POINTS;
      REQ_LOAD_INNER: keep = int'(load_index_i) < MAX_INNER_POINTS;
      REQ_LOAD_TABLE: keep = int'(load_index_i) < TABLE_DEPTH;
      default:        keep = 1'b1;
    endcase
    push_o = start && !queue_full_i && keep;
  end

  // Register write decode.
  assign wr_en = psel && penable && pwrite;

  always_comb begin
    outer_pts_d = outer_pts_q;
    inner_pts_d = inner_pts_q;
    if (wr_en) begin
      unique case (gbi_reg_e'(paddr[2]))
        REG_OUTER_POINTS: outer_pts_d = pwdata[CNT_W-1:0];
        default:          inner_pts_d = pwdata[CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outer_pts_q <= CNT_W'(64);
      inner_pts_q <= CNT_W'(64);
    end else begin
      outer_pts_q <= outer_pts_d;
      inner_pts_q <= inner_pts_d;
    end
  end

  // Read back and effective counts.
  always_comb begin
    unique case (gbi_reg_e'(paddr[2]))
      REG_OUTER_POINTS: prdata = PDATA_W'(outer_pts_q);
      default:          prdata = PDATA_W'(inner_pts_q);
    endcase
  end

  assign pready        = 1'b1;
  assign cfg_o.n_outer = eff_count(outer_pts_q, MAX_OUTER_POINTS);
  assign cfg_o.n_inner = eff_count(inner_pts_q, MAX_INNER_POINTS);

endmodule

`default_nettype wire

>>> src/gbi_queue.sv
// Short item queue that decouples the front end from the back end.
// Depends on gbi_pkg for the item type and depth.
`default_nettype none

module gbi_queue (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  gbi_pkg::gbi_item_t item_i,
  input  wire logic         pop_i,
  output gbi_pkg::gbi_item_t head_o,
  output logic              full_o,
  output logic              empty_o
);
  import gbi_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  gbi_item_t         slot_q [QUEUE_DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;

  assign full_o  = count_q == CW'(QUEUE_DEPTH);
  assign empty_o = count_q == '0;
  assign head_o  = slot_q[rd_ptr_q];

  // Pointer and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
      end
      count_q <= count_q + CW'(push_i) - CW'(pop_i);
    end
  end

  // Item storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> src/gbi_div.sv
// Restoring divider on magnitudes, one quotient bit per cycle.
// Stand-alone; no package needed.
`default_nettype none

module gbi_div #(
  parameter int DW = 48,
  parameter int VW = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [DW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output logic               busy_o,
  output logic [DW-1:0]      quotient_o
);

  localparam int NW = $clog2(DW + 1);

  logic          busy_q;
  logic [NW-1:0] cnt_q;
  logic [DW-1:0] quo_q;
  logic [VW-1:0] rem_q, dvs_q, rem_d;
  logic [VW:0]   trial;
  logic          take;

  // One trial subtraction per cycle.
  always_comb begin
    trial = {rem_q, quo_q[DW-1]};
    take  = trial >= {1'b0, dvs_q};
    rem_d = take ? VW'(trial - {1'b0, dvs_q}) : trial[VW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= NW'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - NW'(1);
      if (cnt_q == NW'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DW-2:0], take};
      rem_q <= rem_d;
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

>>> src/gbi_back.sv
// Back end: grid and table stores, cell search, fractions and blending.
// Depends on gbi_pkg and gbi_div.
`default_nettype none

module gbi_back #(
  parameter int MAX_OUTER_POINTS = gbi_pkg::DEF_MAX_OUTER,
  parameter int MAX_INNER_POINTS = gbi_pkg::DEF_MAX_INNER,
  parameter int FRAC_BITS        = gbi_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  gbi_pkg::gbi_item_t               head_i,
  input  wire logic                        empty_i,
  output logic                             pop_o,
  input  gbi_pkg::gbi_cfg_t                cfg_i,
  output logic                             result_valid_o,
  output logic signed [31:0]               interp_result_o,
  output logic [gbi_pkg::CELL_W-1:0]       outer_cell_o,
  output logic [gbi_pkg::CELL_W-1:0]       inner_cell_o,
  output logic                             zero_span_o,
  output logic                             saturated_o
);
  import gbi_pkg::*;

  localparam int OAW  = (MAX_OUTER_POINTS > 1) ? $clog2(MAX_OUTER_POINTS) : 1;
  localparam int IAW  = (MAX_INNER_POINTS > 1) ? $clog2(MAX_INNER_POINTS) : 1;
  localparam int MAXP = (MAX_OUTER_POINTS > MAX_INNER_POINTS) ? MAX_OUTER_POINTS
                                                              : MAX_INNER_POINTS;
  localparam int CW   = $clog2(MAXP + 1);
  localparam int TD   = MAX_OUTER_POINTS * MAX_INNER_POINTS;
  localparam int TAW  = $clog2(TD);
  localparam int MFW  = 32 + FRAC_BITS;
  localparam int MAGW = 64 + FRAC_BITS;
  localparam int QW   = 64 - FRAC_BITS;

  gbi_state_e state_q, state_d;

  // Stores.
  logic signed [31:0] outer_mem [MAX_OUTER_POINTS];
  logic signed [31:0] inner_mem [MAX_INNER_POINTS];
  logic signed [31:0] table_mem [TD];
  logic signed [31:0] og_q, ig_q, trd_q;
  logic               ow, iw, tw;
  logic [CW-1:0]      raddr [2];
  logic [TAW-1:0]     taddr;

  // Per-axis search and fraction state.
  logic [CW-1:0]      n [2], nm2 [2], mid [2];
  logic [CW-1:0]      lo_q [2], len_q [2], cell_q [2];
  logic               done_q [2], act [2];
  logic signed [31:0] x_q [2], glo_q [2], gdata [2];
  logic signed [32:0] num33 [2], den33 [2];
  logic [31:0]        nmag [2], dmag [2];
  logic               den_zero [2], div_start [2], div_busy [2];
  logic [MFW-1:0]     quo [2];
  logic               fneg_q [2], fzero_q [2];

  // Table corners and blend datapath.
  logic [2*CW-1:0]    prod_q;
  logic [TAW-1:0]     base_q;
  logic signed [31:0] tv_q [4];
  gbi_pass_e          pass_q;
  logic signed [31:0] sa, sb, a_q, left_q, right_q, res_q;
  logic               fsel;
  logic signed [32:0] d33;
  logic [31:0]        md_q;
  logic               neg_q;
  logic [MFW-1:0]     mf_q;
  logic [63:0]        p0_q;
  logic [FRAC_BITS+31:0] p1_q;
  logic [MAGW-1:0]    mag_q;
  logic               ovf, rnd, sat_hi, sat_lo, bl_sat;
  logic [QW:0]        qr;
  logic signed [65:0] sum;
  logic signed [31:0] bl_val;
  logic               zs_q, sat_q, valid_q;

  assign n[0]     = CW'(cfg_i.n_outer);
  assign n[1]     = CW'(cfg_i.n_inner);
  assign gdata[0] = og_q;
  assign gdata[1] = ig_q;

  // Per-axis arithmetic shared by search and fraction setup.
  always_comb begin
    for (int a = 0; a < 2; a++) begin
      nm2[a]      = n[a] - CW'(2);
      mid[a]      = lo_q[a] + (len_q[a] >> 1);
      act[a]      = !done_q[a] && (len_q[a] > CW'(1));
      num33[a]    = {x_q[a][31], x_q[a]} - {glo_q[a][31], glo_q[a]};
      den33[a]    = {gdata[a][31], gdata[a]} - {glo_q[a][31], glo_q[a]};
      nmag[a]     = num33[a][32] ? 32'(-num33[a]) : num33[a][31:0];
      dmag[a]     = den33[a][32] ? 32'(-den33[a]) : den33[a][31:0];
      den_zero[a] = den33[a] == '0;
      div_start[a] = (state_q == S_DIV) && !den_zero[a];
    end
  end

  // Fraction dividers, one per axis.
  gbi_div #(.DW(MFW), .VW(32)) u_div_outer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start[0]),
    .dividend_i ({nmag[0], {FRAC_BITS{1'b0}}}),
    .divisor_i  (dmag[0]),
    .busy_o     (div_busy[0]),
    .quotient_o (quo[0])
  );

  gbi_div #(.DW(MFW), .VW(32)) u_div_inner (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start[1]),
    .dividend_i ({nmag[1], {FRAC_BITS{1'b0}}}),
    .divisor_i  (dmag[1]),
    .busy_o     (div_busy[1]),
    .quotient_o (quo[1])
  );

  // Sequencer: next state, queue pop, store writes and read addresses.
  always_comb begin
    state_d  = state_q;
    pop_o    = 1'b0;
    ow       = 1'b0;
    iw       = 1'b0;
    tw       = 1'b0;
    raddr[0] = '0;
    raddr[1] = '0;
    taddr    = base_q;
    unique case (state_q)
      S_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (head_i.kind)
            REQ_LOAD_OUTER: ow = 1'b1;
            REQ_LOAD_INNER: iw = 1'b1;
            REQ_LOAD_TABLE: tw = 1'b1;
            default:        state_d = S_FIRST;
          endcase
        end
      end
      S_FIRST: state_d = S_LAST;
      S_LAST: begin
        raddr[0] = nm2[0];
        raddr[1] = nm2[1];
        state_d  = S_SETUP;
      end
      S_SETUP: state_d = S_PROBE;
      S_PROBE: begin
        raddr[0] = mid[0];
        raddr[1] = mid[1];
        state_d  = (act[0] || act[1]) ? S_STEP : S_CLAMP;
      end
      S_STEP:  state_d = S_PROBE;
      S_CLAMP: state_d = S_RLO;
      S_RLO: begin
        raddr[0] = cell_q[0];
        raddr[1] = cell_q[1];
        state_d  = S_RHI;
      end
      S_RHI: begin
        raddr[0] = cell_q[0] + CW'(1);
        raddr[1] = cell_q[1] + CW'(1);
        state_d  = S_DIV;
      end
      S_DIV: state_d = S_WAIT;
      S_WAIT: begin
        if (!div_busy[0] && !div_busy[1]) begin
          state_d = S_T0;
        end
      end
      S_T0: state_d = S_T1;
      S_T1: begin
        taddr   = base_q + TAW'(1);
        state_d = S_T2;
      end
      S_T2: begin
        taddr   = base_q + TAW'(n[1]);
        state_d = S_T3;
      end
      S_T3: begin
        taddr   = base_q + TAW'(n[1]) + TAW'(1);
        state_d = S_T4;
      end
      S_T4:   state_d = S_BD;
      S_BD:   state_d = S_BM0;
      S_BM0:  state_d = S_BM1;
      S_BM1:  state_d = S_BACC;
      S_BACC: state_d = S_BFIN;
      S_BFIN: state_d = (pass_q == PASS_FINAL) ? S_IDLE : S_BD;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= (state_q == S_BFIN) && (pass_q == PASS_FINAL);
    end
  end

  // Store ports: one write and one registered read each.
  always_ff @(posedge clk_i) begin
    if (ow) begin
      outer_mem[OAW'(head_i.index)] <= head_i.data;
    end
    og_q <= outer_mem[raddr[0][OAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (iw) begin
      inner_mem[IAW'(head_i.index)] <= head_i.data;
    end
    ig_q <= inner_mem[raddr[1][IAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (tw) begin
      table_mem[TAW'(head_i.index)] <= head_i.data;
    end
    trd_q <= table_mem[taddr];
  end

  // Blend operand selection.
  always_comb begin
    case (pass_q)
      PASS_LEFT: begin
        sa = tv_q[0];
        sb = tv_q[1];
        fsel = 1'b1;
      end
      PASS_RIGHT: begin
        sa = tv_q[2];
        sb = tv_q[3];
        fsel = 1'b1;
      end
      default: begin
        sa = left_q;
        sb = right_q;
        fsel = 1'b0;
      end
    endcase
    d33 = {sb[31], sb} - {sa[31], sa};
  end

  // Blend finish: floor of the scaled product, add and clip.
  always_comb begin
    ovf    = |mag_q[MAGW-1:64];
    rnd    = neg_q && (|mag_q[FRAC_BITS-1:0]);
    qr     = {1'b0, mag_q[63:FRAC_BITS]} + (QW+1)'(rnd);
    sum    = neg_q ? ({{34{a_q[31]}}, a_q} - 66'(qr)) : ({{34{a_q[31]}}, a_q} + 66'(qr));
    sat_hi = !sum[65] && (|sum[64:31]);
    sat_lo = sum[65] && !(&sum[64:31]);
    if (ovf) begin
      bl_sat = 1'b1;
      bl_val = neg_q ? 32'sh80000000 : 32'sh7FFFFFFF;
    end else if (sat_hi) begin
      bl_sat = 1'b1;
      bl_val = 32'sh7FFFFFFF;
    end else if (sat_lo) begin
      bl_sat = 1'b1;
      bl_val = 32'sh80000000;
    end else begin
      bl_sat = 1'b0;
      bl_val = sum[31:0];
    end
  end

  // Datapath registers, loaded by sequencer state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        x_q[0] <= head_i.q_outer;
        x_q[1] <= head_i.q_inner;
        zs_q   <= 1'b0;
        sat_q  <= 1'b0;
        pass_q <= PASS_LEFT;
      end
      S_LAST: begin
        for (int a = 0; a < 2; a++) begin
          done_q[a] <= x_q[a] <= gdata[a];
          cell_q[a] <= '0;
        end
      end
      S_SETUP: begin
        for (int a = 0; a < 2; a++) begin
          if (!done_q[a] && (x_q[a] >= gdata[a])) begin
            done_q[a] <= 1'b1;
            cell_q[a] <= nm2[a];
          end
          lo_q[a]  <= '0;
          len_q[a] <= n[a];
        end
      end
      S_STEP: begin
        for (int a = 0; a < 2; a++) begin
          if (act[a]) begin
            if (gdata[a] <= x_q[a]) begin
              lo_q[a] <= mid[a];
            end
            len_q[a] <= len_q[a] - (len_q[a] >> 1);
          end
        end
      end
      S_CLAMP: begin
        for (int a = 0; a < 2; a++) begin
          if (!done_q[a]) begin
            cell_q[a] <= (lo_q[a] > nm2[a]) ? nm2[a] : lo_q[a];
          end
        end
      end
      S_RLO: prod_q <= cell_q[0] * n[1];
      S_RHI: begin
        glo_q[0] <= og_q;
        glo_q[1] <= ig_q;
      end
      S_DIV: begin
        for (int a = 0; a < 2; a++) begin
          fzero_q[a] <= den_zero[a];
          fneg_q[a]  <= num33[a][32] ^ den33[a][32];
        end
        zs_q   <= den_zero[0] || den_zero[1];
        base_q <= TAW'(prod_q + (2*CW)'(cell_q[1]));
      end
      S_T1: tv_q[0] <= trd_q;
      S_T2: tv_q[1] <= trd_q;
      S_T3: tv_q[2] <= trd_q;
      S_T4: tv_q[3] <= trd_q;
      S_BD: begin
        a_q   <= sa;
        md_q  <= d33[32] ? 32'(-d33) : d33[31:0];
        neg_q <= d33[32] ^ fneg_q[fsel];
        mf_q  <= fzero_q[fsel] ? '0 : quo[fsel];
      end
      S_BM0:  p0_q  <= md_q * mf_q[31:0];
      S_BM1:  p1_q  <= md_q * mf_q[MFW-1:32];
      S_BACC: mag_q <= {p1_q, 32'b0} + MAGW'(p0_q);
      S_BFIN: begin
        sat_q <= sat_q || bl_sat;
        case (pass_q)
          PASS_LEFT: begin
            left_q <= bl_val;
            pass_q <= PASS_RIGHT;
          end
          PASS_RIGHT: begin
            right_q <= bl_val;
            pass_q  <= PASS_FINAL;
          end
          default: res_q <= bl_val;
        endcase
      end
      default: begin
      end
    endcase
  end

  assign result_valid_o  = valid_q;
  assign interp_result_o = res_q;
  assign outer_cell_o    = CELL_W'(cell_q[0]);
  assign inner_cell_o    = CELL_W'(cell_q[1]);
  assign zero_span_o     = zs_q;
  assign saturated_o     = sat_q;

  // A result follows only the last blend pass.
  a_result_after_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> ($past(state_q) == S_BFIN && $past(pass_q) == PASS_FINAL))
    else $error("result strobe without a finished final blend");

  // Chosen cells never pass the last cell of the axis.
  a_cell_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> (cell_q[0] <= nm2[0] && cell_q[1] <= nm2[1]))
    else $error("cell index beyond last cell");

  // A zero-width outer axis never starts its divider.
  a_zero_span_no_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WAIT && fzero_q[0]) |-> !div_busy[0])
    else $error("outer divider running on a zero-width cell");

  // Stores are written only between queries.
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ow || iw || tw) |-> (state_q == S_IDLE && pop_o))
    else $error("store write outside idle");

endmodule

`default_nettype wire

>>> src/grid_bilinear_interpolation.sv
// Top level of the grid bilinear interpolation block.
// Depends on gbi_pkg, gbi_front, gbi_queue and gbi_back.
`default_nettype none

// Usage:
// Items are transferred on start while busy is low. req_type selects a load
// of an outer grid point, an inner grid point or a table value (load_index,
// load_data), or a query (query_outer, query_inner). Loads beyond a store's
// depth are dropped and give no result.
// Each query gives one result, shown for one cycle with result_valid_o; the
// receiver cannot stall, so no back pressure exists on that side.
// A two-entry queue sits between the item port and the sequencer, so busy
// rises only when both entries wait.
// A load is handled in the sequencer's idle state without leaving it. A query
// runs a halving cell search, the bit-serial fraction divider (32 + FRAC_BITS
// steps) and three blends, one after another, on one shared blend datapath.
// The point count registers sit on the APB port at byte addresses 0 and 4
// and reset to 64. Reset empties the queue; grid and table contents are
// undefined until loaded.
module grid_bilinear_interpolation #(
  parameter int MAX_OUTER_POINTS = gbi_pkg::DEF_MAX_OUTER,
  parameter int MAX_INNER_POINTS = gbi_pkg::DEF_MAX_INNER,
  parameter int FRAC_BITS        = gbi_pkg::DEF_FRAC_BITS
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [1:0]                   req_type_i,
  input  wire logic [gbi_pkg::IDX_W-1:0]    load_index_i,
  input  wire logic signed [31:0]           load_data_i,
  input  wire logic signed [31:0]           query_outer_i,
  input  wire logic signed [31:0]           query_inner_i,
  output logic                              result_valid_o,
  output logic signed [31:0]                interp_result_o,
  output logic [gbi_pkg::CELL_W-1:0]        outer_cell_o,
  output logic [gbi_pkg::CELL_W-1:0]        inner_cell_o,
  output logic                              zero_span_o,
  output logic                              saturated_o,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [gbi_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [gbi_pkg::PDATA_W-1:0]  pwdata,
  output logic [gbi_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import gbi_pkg::*;

  gbi_item_t item, head;
  gbi_cfg_t  cfg;
  logic      push, pop, full, empty;

  assign busy = full;

  // Front end: item classification and configuration registers.
  gbi_front #(
    .MAX_OUTER_POINTS (MAX_OUTER_POINTS),
    .MAX_INNER_POINTS (MAX_INNER_POINTS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .req_type_i    (req_type_i),
    .load_index_i  (load_index_i),
    .load_data_i   (load_data_i),
    .query_outer_i (query_outer_i),
    .query_inner_i (query_inner_i),
    .queue_full_i  (full),
    .item_o        (item),
    .push_o        (push),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .cfg_o         (cfg)
  );

  // Queue between the two halves.
  gbi_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  // Back end: stores, search, divide and blend.
  gbi_back #(
    .MAX_OUTER_POINTS (MAX_OUTER_POINTS),
    .MAX_INNER_POINTS (MAX_INNER_POINTS),
    .FRAC_BITS        (FRAC_BITS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head),
    .empty_i         (empty),
    .pop_o           (pop),
    .cfg_i           (cfg),
    .result_valid_o  (result_valid_o),
    .interp_result_o (interp_result_o),
    .outer_cell_o    (outer_cell_o),
    .inner_cell_o    (inner_cell_o),
    .zero_span_o     (zero_span_o),
    .saturated_o     (saturated_o)
  );

endmodule

`default_nettype wire

>>> tb/sv/tb.sv
// Self-checking testbench for grid_bilinear_interpolation.
// Depends on gbi_pkg and the RTL in src; a built-in predictor checks every query result.
`timescale 1ns / 1ps

module tb;
  import gbi_pkg::*;

  localparam int NPTS      = 64;
  localparam int TBL_DEPTH = NPTS * NPTS;
  localparam int FBITS     = 16;
  localparam int SETTLE    = 200;
  localparam int LIMIT     = 1000000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct {
    gbi_req_e    kind;
    logic [11:0] index;
    logic [31:0] data;
    logic [31:0] q_outer;
    logic [31:0] q_inner;
  } grid_item_t;

  typedef struct {
    logic [31:0] value;
    logic [5:0]  o_cell;
    logic [5:0]  i_cell;
    logic        zspan;
    logic        sat;
  } interp_out_t;

  logic        clk_i, rst_ni, start, busy;
  logic [1:0]  req_type_i;
  logic [11:0] load_index_i;
  logic signed [31:0] load_data_i, query_outer_i, query_inner_i;
  logic        result_valid_o;
  logic signed [31:0] interp_result_o;
  logic [5:0]  outer_cell_o, inner_cell_o;
  logic        zero_span_o, saturated_o;
  logic        psel, penable, pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata, prdata;
  logic        pready;

  grid_bilinear_interpolation i_dut (
    .clk_i, .rst_ni, .start, .busy,
    .req_type_i, .load_index_i, .load_data_i, .query_outer_i, .query_inner_i,
    .result_valid_o, .interp_result_o, .outer_cell_o, .inner_cell_o,
    .zero_span_o, .saturated_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  // Predictor state: stores and point count registers as the block holds them.
  logic [31:0] outer_pts [NPTS];
  logic [31:0] inner_pts [NPTS];
  logic [31:0] values    [TBL_DEPTH];
  logic [6:0]  outer_cnt_reg, inner_cnt_reg;

  // Intended grids of the current phase, used to aim query coordinates.
  longint plan_outer [NPTS];
  longint plan_inner [NPTS];

  grid_item_t  pending_items [$];
  interp_out_t expected_results [$];
  grid_item_t  cur_item, nxt_item;
  int          burst_left, gap_left;
  int          errors;
  int          cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic int unsigned clamp_count(input logic [6:0] r);
    if (r < 2) return 2;
    if (r > NPTS) return NPTS;
    return r;
  endfunction

  function automatic longint grid_at(input bit is_outer, input int unsigned i);
    logic signed [31:0] v;
    v = is_outer ? outer_pts[i] : inner_pts[i];
    return longint'(v);
  endfunction

  function automatic longint clip_s32(input longint v, inout bit sat);
    if (v > S32_MAX) begin
      sat = 1'b1;
      return S32_MAX;
    end
    if (v < S32_MIN) begin
      sat = 1'b1;
      return S32_MIN;
    end
    return v;
  endfunction

  // Halving search for the lower cell index, clamped at both ends.
  function automatic int unsigned search_cell(input bit is_outer, input int unsigned n,
                                              input longint x);
    int unsigned lo, len, half;
    lo  = 0;
    len = n;
    if (x <= grid_at(is_outer, 0)) return 0;
    if (x >= grid_at(is_outer, n - 2)) return n - 2;
    half = len / 2;
    while (half != 0) begin
      if (grid_at(is_outer, lo + half) <= x) lo = lo + half;
      len  = len - half;
      half = len / 2;
    end
    if (lo > n - 2) lo = n - 2;
    return lo;
  endfunction

  function automatic longint cell_fraction(input bit is_outer, input int unsigned c,
                                           input longint x, inout bit zspan);
    longint lo, den;
    lo  = grid_at(is_outer, c);
    den = grid_at(is_outer, c + 1) - lo;
    if (den == 0) begin
      zspan = 1'b1;
      return 0;
    end
    return ((x - lo) * (64'sd1 <<< FBITS)) / den;
  endfunction

  // a + floor(f * (b - a) / 2^FBITS), exact, then clipped.
  function automatic longint blend_fx(input longint a, input longint b, input longint f,
                                      inout bit sat);
    longint d, off;
    logic [63:0] md, mf, q;
    logic [127:0] mag;
    bit neg;
    d   = b - a;
    neg = (d < 0) != (f < 0);
    md  = (d < 0) ? -d : d;
    mf  = (f < 0) ? -f : f;
    if (md == 0 || mf == 0) return a;
    mag = {64'b0, mf} * {64'b0, md};
    if (mag[127:64] != 0) begin
      sat = 1'b1;
      return neg ? S32_MIN : S32_MAX;
    end
    q = mag[63:0] >> FBITS;
    if (neg && mag[FBITS-1:0] != 0) q = q + 1;
    off = neg ? -longint'(q) : longint'(q);
    return clip_s32(a + off, sat);
  endfunction

  // Applies one accepted transfer to the predictor; queries queue a result.
  task automatic apply_item(input grid_item_t it);
    int unsigned n1, n2, c1, c2, b0, b1;
    longint x1, x2, f1, f2, left, right, res;
    logic signed [31:0] t0, t1, t2, t3;
    bit zspan, sat;
    interp_out_t r;
    zspan = 1'b0;
    sat   = 1'b0;
    case (it.kind)
      REQ_LOAD_OUTER: if (it.index < NPTS) outer_pts[it.index] = it.data;
      REQ_LOAD_INNER: if (it.index < NPTS) inner_pts[it.index] = it.data;
      REQ_LOAD_TABLE: values[it.index] = it.data;
      default: begin
        n1 = clamp_count(outer_cnt_reg);
        n2 = clamp_count(inner_cnt_reg);
        x1 = longint'($signed(it.q_outer));
        x2 = longint'($signed(it.q_inner));
        c1 = search_cell(1'b1, n1, x1);
        c2 = search_cell(1'b0, n2, x2);
        f1 = cell_fraction(1'b1, c1, x1, zspan);
        f2 = cell_fraction(1'b0, c2, x2, zspan);
        b0 = c1 * n2 + c2;
        b1 = (c1 + 1) * n2 + c2;
        t0 = values[b0];
        t1 = values[b0 + 1];
        t2 = values[b1];
        t3 = values[b1 + 1];
        left  = blend_fx(longint'(t0), longint'(t1), f2, sat);
        right = blend_fx(longint'(t2), longint'(t3), f2, sat);
        res   = blend_fx(left, right, f1, sat);
        r.value  = res[31:0];
        r.o_cell = c1[5:0];
        r.i_cell = c2[5:0];
        r.zspan  = zspan;
        r.sat    = sat;
        expected_results.push_back(r);
      end
    endcase
  endtask

  // Driver: bursts of transfers separated by random gaps.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start         <= 1'b0;
      req_type_i    <= 2'b0;
      load_index_i  <= '0;
      load_data_i   <= '0;
      query_outer_i <= '0;
      query_inner_i <= '0;
      burst_left    <= 1;
      gap_left      <= 0;
    end else begin
      if (start && !busy) apply_item(cur_item);
      if (start && busy) begin
        // Hold the item until it is taken.
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_items.size() != 0) begin
        nxt_item      = pending_items.pop_front();
        cur_item      <= nxt_item;
        req_type_i    <= nxt_item.kind;
        load_index_i  <= nxt_item.index;
        load_data_i   <= nxt_item.data;
        query_outer_i <= nxt_item.q_outer;
        query_inner_i <= nxt_item.q_inner;
        start         <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 24);
          gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: every strobed result is checked against the oldest expectation.
  always @(posedge clk_i) begin
    interp_out_t e;
    if (rst_ni && result_valid_o) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result transfer with no query waiting");
      end else begin
        e = expected_results.pop_front();
        if (interp_result_o !== e.value)
          report_mismatch($sformatf("interp_result %h, predicted %h", interp_result_o, e.value));
        if (outer_cell_o !== e.o_cell)
          report_mismatch($sformatf("outer_cell %0d, predicted %0d", outer_cell_o, e.o_cell));
        if (inner_cell_o !== e.i_cell)
          report_mismatch($sformatf("inner_cell %0d, predicted %0d", inner_cell_o, e.i_cell));
        if (zero_span_o !== e.zspan)
          report_mismatch($sformatf("zero_span %b, predicted %b", zero_span_o, e.zspan));
        if (saturated_o !== e.sat)
          report_mismatch($sformatf("saturated %b, predicted %b", saturated_o, e.sat));
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("grid_bilinear_interpolation verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] to_s32(input longint v);
    if (v > S32_MAX) return S32_MAX[31:0];
    if (v < S32_MIN) return S32_MIN[31:0];
    return v[31:0];
  endfunction

  task automatic add_item(input gbi_req_e k, input logic [11:0] idx, input logic [31:0] d,
                          input logic [31:0] qo, input logic [31:0] qi);
    grid_item_t it;
    it.kind    = k;
    it.index   = idx;
    it.data    = d;
    it.q_outer = qo;
    it.q_inner = qi;
    pending_items.push_back(it);
  endtask

  task automatic add_query(input longint qo, input longint qi);
    add_item(REQ_QUERY, 12'($urandom), $urandom, to_s32(qo), to_s32(qi));
  endtask

  // Grid shapes: 0 ascending, 1 ascending with repeats, 2 unsorted, 3 wide ascending.
  task automatic load_grid(input bit is_outer, input int unsigned n, input int shape);
    longint v;
    v = (shape == 3) ? -64'sd1073741824 : longint'($urandom_range(0, 2 << 20)) - (1 << 20);
    for (int i = 0; i < n; i++) begin
      if (shape == 2 && $urandom_range(0, 2) == 0) v = longint'($signed($urandom));
      if (is_outer) plan_outer[i] = v;
      else          plan_inner[i] = v;
      add_item(is_outer ? REQ_LOAD_OUTER : REQ_LOAD_INNER, i, v[31:0], $urandom, $urandom);
      case (shape)
        1:       v = v + (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 1 << 18));
        2:       v = v + $urandom_range(1, 1 << 18);
        3:       v = v + $urandom_range(1 << 20, 1 << 24);
        default: v = v + $urandom_range(1, 1 << 18);
      endcase
    end
  endtask

  function automatic logic [31:0] table_value(input bit wide);
    if (wide) return $urandom;
    return 32'($signed($urandom_range(0, 1 << 22)) - (1 << 21));
  endfunction

  // Coordinate on one axis: mostly inside or near the grid, sometimes anywhere.
  function automatic longint pick_coord(input bit is_outer, input int unsigned n);
    longint lo, hi, w;
    logic [63:0] r;
    lo = is_outer ? plan_outer[0] : plan_inner[0];
    hi = is_outer ? plan_outer[n - 1] : plan_inner[n - 1];
    if (lo > hi) begin
      w  = lo;
      lo = hi;
      hi = w;
    end
    case ($urandom_range(0, 9))
      0: return longint'($signed($urandom));
      1: return is_outer ? plan_outer[$urandom_range(0, n - 1)]
                         : plan_inner[$urandom_range(0, n - 1)];
      default: begin
        w = (hi - lo) + (hi - lo) / 2 + 1;
        r = {$urandom, $urandom};
        return lo - (hi - lo) / 4 + longint'(r % w);
      end
    endcase
  endfunction

  task automatic write_reg(input gbi_reg_e r, input logic [6:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= {25'b0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (r == REG_OUTER_POINTS) outer_cnt_reg = v;
    else                       inner_cnt_reg = v;
  endtask

  // Waits until every item is taken, every result is in, and loads have settled.
  task automatic drain();
    wait (pending_items.size() == 0 && !start);
    wait (expected_results.size() == 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // One phase: program counts, load grids and table, then random traffic.
  task automatic run_phase(input logic [6:0] oreg, input logic [6:0] ireg, input int shape,
                           input int n_queries);
    int unsigned n1, n2;
    bit wide;
    write_reg(REG_OUTER_POINTS, oreg);
    write_reg(REG_INNER_POINTS, ireg);
    n1   = clamp_count(oreg);
    n2   = clamp_count(ireg);
    wide = ($urandom_range(0, 3) == 0);
    load_grid(1'b1, n1, shape);
    load_grid(1'b0, n2, (shape == 2) ? 0 : shape);
    for (int i = 0; i < n1 * n2; i++)
      add_item(REQ_LOAD_TABLE, i, table_value(wide), $urandom, $urandom);
    for (int i = 0; i < n_queries; i++) begin
      case ($urandom_range(0, 19))
        0: add_item(REQ_LOAD_TABLE, $urandom_range(0, n1 * n2 - 1), table_value(1'b1),
                    $urandom, $urandom);
        1: add_item(REQ_LOAD_TABLE, $urandom, $urandom, $urandom, $urandom);
        2: add_item($urandom_range(0, 1) ? REQ_LOAD_OUTER : REQ_LOAD_INNER,
                    $urandom_range(NPTS, 4095), $urandom, $urandom, $urandom);
        default: add_query(pick_coord(1'b1, n1), pick_coord(1'b0, n2));
      endcase
    end
    drain();
  endtask

  initial begin
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    errors        = 0;
    cycles        = 0;
    outer_cnt_reg = 7'd64;
    inner_cnt_reg = 7'd64;
    for (int i = 0; i < TBL_DEPTH; i++) values[i] = '0;
    for (int i = 0; i < NPTS; i++) begin
      outer_pts[i] = '0;
      inner_pts[i] = '0;
    end
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: two-point grids, extremes, exact points, ignored loads,
    // zero-width cells and saturating extrapolation.
    write_reg(REG_OUTER_POINTS, 7'd2);
    write_reg(REG_INNER_POINTS, 7'd2);
    plan_outer[0] = 0;
    plan_outer[1] = 64'sd65536;
    plan_inner[0] = -64'sd65536;
    plan_inner[1] = 64'sd131072;
    add_item(REQ_LOAD_OUTER, 0, 32'h0, '0, '0);
    add_item(REQ_LOAD_OUTER, 1, 32'h0001_0000, '0, '0);
    add_item(REQ_LOAD_INNER, 0, 32'hFFFF_0000, '0, '0);
    add_item(REQ_LOAD_INNER, 1, 32'h0002_0000, '0, '0);
    add_item(REQ_LOAD_TABLE, 0, 32'h0001_0000, '0, '0);
    add_item(REQ_LOAD_TABLE, 1, 32'h0003_0000, '0, '0);
    add_item(REQ_LOAD_TABLE, 2, 32'hFFFE_0000, '0, '0);
    add_item(REQ_LOAD_TABLE, 3, 32'h0005_8000, '0, '0);
    add_item(REQ_LOAD_OUTER, 12'd64, 32'h7FFF_FFFF, '0, '0);
    add_item(REQ_LOAD_INNER, 12'hFFF, 32'h8000_0000, '0, '0);
    add_query(0, -65536);
    add_query(65536, 131072);
    add_query(32768, 12345);
    add_query(-64'sd2147483648, -64'sd2147483648);
    add_query(64'sd2147483647, 64'sd2147483647);
    add_query(64'sd2147483647, -64'sd2147483648);
    add_item(REQ_LOAD_TABLE, 3, 32'h7FFF_FFFF, '0, '0);
    add_item(REQ_LOAD_TABLE, 0, 32'h8000_0000, '0, '0);
    add_query(64'sd2147483647, 64'sd2147483647);
    add_query(-64'sd2147483648, 64'sd1000000);
    add_query(12, 7);
    add_item(REQ_LOAD_OUTER, 1, 32'h0, '0, '0);
    add_query(100, 50000);
    add_query(-100, 64'sd2147483647);
    add_item(REQ_LOAD_OUTER, 1, 32'h0001_0000, '0, '0);
    add_item(REQ_LOAD_INNER, 1, 32'hFFFF_0000, '0, '0);
    add_query(40000, -65536);
    drain();

    run_phase(7'd2, 7'd2, 0, 40);
    run_phase(7'd127, 7'd1, 1, 60);
    run_phase(7'd0, 7'd64, 0, 60);
    run_phase(7'd7, 7'd5, 2, 60);
    run_phase(7'd12, 7'd9, 1, 60);
    run_phase(7'd3, 7'd3, 3, 50);

    if (errors == 0) begin
      $display("grid_bilinear_interpolation verification clean");
    end else begin
      $display("grid_bilinear_interpolation verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/gbi_pkg.sv
src/gbi_front.sv
src/gbi_queue.sv
src/gbi_div.sv
src/gbi_back.sv
src/grid_bilinear_interpolation.sv
tb/sv/tb.sv
